FILE: hw/rtl/target_lock_qualifier_macros.svh
// Assertion macros shared by the checker files of the target lock qualifier.
`ifndef TARGET_LOCK_QUALIFIER_MACROS_SVH
`define TARGET_LOCK_QUALIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("target_lock_qualifier assertion failed");

// Next-cycle implication, checked outside reset.
`define TLQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("target_lock_qualifier assertion failed");

`endif

FILE: hw/rtl/tlq_pkg.sv
// Types and constants shared by the target lock qualifier modules.
package tlq_pkg;

  localparam logic [3:0] CAUSE_OK          = 4'd0;
  localparam logic [3:0] CAUSE_NO_FOLLOW   = 4'd1;
  localparam logic [3:0] CAUSE_NO_MSG      = 4'd2;
  localparam logic [3:0] CAUSE_NO_TRACK    = 4'd3;
  localparam logic [3:0] CAUSE_NO_NAV      = 4'd4;
  localparam logic [3:0] CAUSE_NOT_FINITE  = 4'd5;
  localparam logic [3:0] CAUSE_BAD_STAMP   = 4'd6;
  localparam logic [3:0] CAUSE_EXPIRED     = 4'd7;
  localparam logic [3:0] CAUSE_WARMING     = 4'd8;

  localparam logic [8:0] NO_PENDING = 9'h1FF;

  localparam logic [2:0] REG_TIMEOUT    = 3'd0;
  localparam logic [2:0] REG_OVERRIDE   = 3'd1;
  localparam logic [2:0] REG_ACTIVATION = 3'd2;
  localparam logic [2:0] REG_SWITCH     = 3'd3;
  localparam logic [2:0] REG_NAV        = 3'd4;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [15:0] override_hold_ms;
    logic [15:0] activation_hold_ms;
    logic [15:0] switch_hold_ms;
    logic        require_nav;
  } cfg_t;

  typedef struct packed {
    logic        msg_present;
    logic        follow_allowed;
    logic        tracking;
    logic        nav_flag;
    logic [31:0] yaw_bits;
    logic [31:0] pitch_bits;
    logic [7:0]  sample_id;
    logic [31:0] stamp_ms;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic        latched;
    logic [31:0] hold_deadline;
    logic        hold_deadline_valid;
    logic [31:0] warmup_start;
    logic        warmup_active;
    logic [31:0] switch_start;
    logic        switch_active;
    logic [8:0]  pending_id;
    logic [31:0] kept_yaw;
    logic [31:0] kept_pitch;
    logic [7:0]  kept_id;
  } state_t;

  typedef struct packed {
    logic        success;
    logic        held;
    logic [31:0] out_yaw;
    logic [31:0] out_pitch;
    logic [7:0]  out_id;
    logic [3:0]  cause;
  } result_t;

endpackage

FILE: hw/rtl/target_lock_qualifier.sv
// Top level of the target lock qualifier: register port, sample stage, lock state, result stage.
//
//   channel   handshake            payload
//   input     in_valid / in_stall   msg_present .. now_ms, one sample word
//   output    out_valid / out_stall success, held, out_yaw, out_pitch, out_id, cause
//   config    APB write / read      timeout and hold registers, require_nav
//
// A word is registered in the sample register and then in the result register, from which its result word is
// presented; one word is accepted in every cycle unless in_stall is raised.
// The lock state is updated as a word leaves the sample register, which sets the rate.
// rst is synchronous and resets the registers to their defaults, the lock state and both stages.
// A stall on the output holds the result word, and the sample stage then stalls the input.
module target_lock_qualifier
  import tlq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        msg_present,
  input  logic        follow_allowed,
  input  logic        tracking,
  input  logic        nav_flag,
  input  logic [31:0] yaw_bits,
  input  logic [31:0] pitch_bits,
  input  logic [7:0]  sample_id,
  input  logic [31:0] stamp_ms,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        success,
  output logic        held,
  output logic [31:0] out_yaw,
  output logic [31:0] out_pitch,
  output logic [7:0]  out_id,
  output logic [3:0]  cause
);

  cfg_t    cfg;
  sample_t smp;
  logic    smp_valid;
  state_t  st;
  state_t  st_next;
  result_t res;
  result_t res_reg;
  logic    advance;
  logic    cfg_write;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms         <= 16'd500;
      cfg.override_hold_ms   <= 16'd0;
      cfg.activation_hold_ms <= 16'd0;
      cfg.switch_hold_ms     <= 16'd0;
      cfg.require_nav        <= 1'b1;
    end else if (cfg_write) begin
      case (reg_index)
        REG_TIMEOUT:    cfg.timeout_ms         <= pwdata[15:0];
        REG_OVERRIDE:   cfg.override_hold_ms   <= pwdata[15:0];
        REG_ACTIVATION: cfg.activation_hold_ms <= pwdata[15:0];
        REG_SWITCH:     cfg.switch_hold_ms     <= pwdata[15:0];
        REG_NAV:        cfg.require_nav        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_TIMEOUT:    prdata = {16'd0, cfg.timeout_ms};
      REG_OVERRIDE:   prdata = {16'd0, cfg.override_hold_ms};
      REG_ACTIVATION: prdata = {16'd0, cfg.activation_hold_ms};
      REG_SWITCH:     prdata = {16'd0, cfg.switch_hold_ms};
      REG_NAV:        prdata = {31'd0, cfg.require_nav};
      default:        prdata = 32'd0;
    endcase
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = smp_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (!in_stall) begin
      smp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      smp.msg_present    <= msg_present;
      smp.follow_allowed <= follow_allowed;
      smp.tracking       <= tracking;
      smp.nav_flag       <= nav_flag;
      smp.yaw_bits       <= yaw_bits;
      smp.pitch_bits     <= pitch_bits;
      smp.sample_id      <= sample_id;
      smp.stamp_ms       <= stamp_ms;
      smp.now_ms         <= now_ms;
    end
  end

  tlq_decide u_decide (
    .cfg     (cfg),
    .st      (st),
    .smp     (smp),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.latched             <= 1'b0;
      st.hold_deadline       <= 32'd0;
      st.hold_deadline_valid <= 1'b0;
      st.warmup_start        <= 32'd0;
      st.warmup_active       <= 1'b0;
      st.switch_start        <= 32'd0;
      st.switch_active       <= 1'b0;
      st.pending_id          <= NO_PENDING;
      st.kept_yaw            <= 32'd0;
      st.kept_pitch          <= 32'd0;
      st.kept_id             <= 8'd0;
    end else if (advance && smp_valid) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && smp_valid) begin
      res_reg <= res;
    end
  end

  assign success   = res_reg.success;
  assign held      = res_reg.held;
  assign out_yaw   = res_reg.out_yaw;
  assign out_pitch = res_reg.out_pitch;
  assign out_id    = res_reg.out_id;
  assign cause     = res_reg.cause;

endmodule

FILE: hw/rtl/tlq_decide.sv
// Decision logic: qualifies one sample against the lock state and gives the next state.
module tlq_decide
  import tlq_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  st,
  input  sample_t smp,
  output state_t  st_next,
  output result_t res
);

  logic        nav_ok;
  logic        angles_ok;
  logic        stamp_ok;
  logic        fresh;
  logic        sample_ok;
  logic        hold_ok;
  logic        ok;
  logic        held_flag;
  logic [3:0]  cause_code;
  logic [31:0] age;
  logic [31:0] hold_left;
  logic [31:0] warm_elapsed;
  logic [31:0] switch_elapsed;
  logic [31:0] deadline_new;
  logic        ovr_on;
  logic [8:0]  id_ext;

  always_comb begin
    nav_ok    = !cfg.require_nav || smp.nav_flag;
    angles_ok = (smp.yaw_bits[30:23] != 8'hFF) && (smp.pitch_bits[30:23] != 8'hFF);
    stamp_ok  = smp.stamp_ms != 32'd0;
    age       = smp.now_ms - smp.stamp_ms;
    fresh     = stamp_ok && ((cfg.timeout_ms == 16'd0) ||
                 ($signed(age) <= $signed({16'd0, cfg.timeout_ms})));
    sample_ok = smp.tracking && nav_ok && angles_ok && stamp_ok && fresh;
    hold_left = smp.now_ms - st.hold_deadline;
    ovr_on    = cfg.override_hold_ms != 16'd0;
    hold_ok   = ovr_on && st.latched && st.hold_deadline_valid &&
                ($signed(hold_left) <= $signed(32'd0));
    deadline_new = smp.now_ms + {16'd0, cfg.override_hold_ms};
    id_ext    = {1'b0, smp.sample_id};

    st_next        = st;
    ok             = 1'b0;
    held_flag      = 1'b0;
    cause_code     = CAUSE_OK;
    warm_elapsed   = 32'd0;
    switch_elapsed = 32'd0;

    if (!smp.msg_present || (smp.follow_allowed && !sample_ok)) begin
      if (!smp.msg_present) begin
        cause_code = CAUSE_NO_MSG;
      end else begin
        st_next.warmup_active = 1'b0;
        st_next.warmup_start  = 32'd0;
        st_next.switch_active = 1'b0;
        st_next.switch_start  = 32'd0;
        st_next.pending_id    = NO_PENDING;
        if (!smp.tracking) begin
          cause_code = CAUSE_NO_TRACK;
        end else if (!nav_ok) begin
          cause_code = CAUSE_NO_NAV;
        end else if (!angles_ok) begin
          cause_code = CAUSE_NOT_FINITE;
        end else if (!stamp_ok) begin
          cause_code = CAUSE_BAD_STAMP;
        end else begin
          cause_code = CAUSE_EXPIRED;
        end
      end
      if (hold_ok) begin
        ok        = 1'b1;
        held_flag = 1'b1;
      end else begin
        st_next.latched             = 1'b0;
        st_next.hold_deadline_valid = 1'b0;
        st_next.hold_deadline       = 32'd0;
        st_next.warmup_active       = 1'b0;
        st_next.warmup_start        = 32'd0;
        st_next.switch_active       = 1'b0;
        st_next.switch_start        = 32'd0;
        st_next.pending_id          = NO_PENDING;
      end
    end else if (!smp.follow_allowed) begin
      cause_code                  = CAUSE_NO_FOLLOW;
      st_next.latched             = 1'b0;
      st_next.hold_deadline_valid = 1'b0;
      st_next.hold_deadline       = 32'd0;
      st_next.warmup_active       = 1'b0;
      st_next.warmup_start        = 32'd0;
      st_next.switch_active       = 1'b0;
      st_next.switch_start        = 32'd0;
      st_next.pending_id          = NO_PENDING;
    end else begin
      ok = 1'b1;
      if (!st.latched) begin
        if (!st.warmup_active || (st.pending_id != id_ext)) begin
          st_next.warmup_active = 1'b1;
          st_next.warmup_start  = smp.now_ms;
          st_next.pending_id    = id_ext;
        end
        warm_elapsed = smp.now_ms - st_next.warmup_start;
        if ((cfg.activation_hold_ms != 16'd0) &&
            ($signed(warm_elapsed) < $signed({16'd0, cfg.activation_hold_ms}))) begin
          ok         = 1'b0;
          cause_code = CAUSE_WARMING;
        end else begin
          st_next.kept_yaw      = smp.yaw_bits;
          st_next.kept_pitch    = smp.pitch_bits;
          st_next.kept_id       = smp.sample_id;
          st_next.latched       = 1'b1;
          st_next.warmup_active = 1'b0;
          st_next.switch_active = 1'b0;
          st_next.pending_id    = id_ext;
          st_next.hold_deadline_valid = ovr_on;
          st_next.hold_deadline       = ovr_on ? deadline_new : 32'd0;
        end
      end else if (smp.sample_id != st.kept_id) begin
        if (!st.switch_active || (st.pending_id != id_ext)) begin
          st_next.switch_active = 1'b1;
          st_next.switch_start  = smp.now_ms;
          st_next.pending_id    = id_ext;
        end
        switch_elapsed = smp.now_ms - st_next.switch_start;
        if ((cfg.switch_hold_ms != 16'd0) &&
            ($signed(switch_elapsed) < $signed({16'd0, cfg.switch_hold_ms}))) begin
          if (ovr_on) begin
            st_next.hold_deadline       = deadline_new;
            st_next.hold_deadline_valid = 1'b1;
          end
        end else begin
          st_next.kept_yaw      = smp.yaw_bits;
          st_next.kept_pitch    = smp.pitch_bits;
          st_next.kept_id       = smp.sample_id;
          st_next.latched       = 1'b1;
          st_next.warmup_active = 1'b0;
          st_next.switch_active = 1'b0;
          st_next.pending_id    = id_ext;
          st_next.hold_deadline_valid = ovr_on;
          st_next.hold_deadline       = ovr_on ? deadline_new : 32'd0;
        end
      end else begin
        st_next.switch_active       = 1'b0;
        st_next.switch_start        = 32'd0;
        st_next.pending_id          = id_ext;
        st_next.kept_yaw            = smp.yaw_bits;
        st_next.kept_pitch          = smp.pitch_bits;
        st_next.hold_deadline_valid = ovr_on;
        st_next.hold_deadline       = ovr_on ? deadline_new : 32'd0;
      end
    end

    res.success   = ok;
    res.held      = held_flag;
    res.out_yaw   = ok ? st_next.kept_yaw : 32'd0;
    res.out_pitch = ok ? st_next.kept_pitch : 32'd0;
    res.out_id    = ok ? st_next.kept_id : 8'd0;
    res.cause     = cause_code;
  end

endmodule

FILE: hw/rtl/tlq_checker.sv
// Port checker for the target lock qualifier and its bind to the top level.
`include "target_lock_qualifier_macros.svh"

module tlq_checker
  import tlq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        success,
  input logic        held,
  input logic [31:0] out_yaw,
  input logic [31:0] out_pitch,
  input logic [7:0]  out_id,
  input logic [3:0]  cause
);

  `TLQ_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && !success,
    !held && out_yaw == 32'd0 && out_pitch == 32'd0 && out_id == 8'd0)

  `TLQ_ASSERT_NOW(a_held_reason, clk, rst, out_valid && held,
    success && cause != CAUSE_OK && cause != CAUSE_NO_FOLLOW && cause != CAUSE_WARMING)

  `TLQ_ASSERT_NOW(a_ok_cause, clk, rst, out_valid && success && !held, cause == CAUSE_OK)

  `TLQ_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(cause) && $stable(out_yaw) && $stable(success))

endmodule

bind target_lock_qualifier tlq_checker u_tlq_checker (.*);
